[src/dpb_pkg.sv]
// Shared types and constants for the depth pixel back-projection block.
// Used by dpb_ctrl, dpb_datapath and the top level; depends on nothing.
package dpb_pkg;

	localparam int MAX_COLS = 2048;
	localparam int MAX_ROWS = 2048;
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int IDX_W = (COL_W > ROW_W) ? COL_W : ROW_W;

	localparam int COEF_W = 32;
	localparam int DEPTH_W = 16;
	localparam int COORD_W = 40;
	localparam int STEP_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// multiplier: COEF_W signed by MB_W signed
	localparam int MB_W = DEPTH_W + 1;
	localparam int MUL_W = COEF_W + MB_W;
	// coefficient sum (three terms of COEF_W x IDX_W)
	localparam int SUM_W = COEF_W + IDX_W + 2;
	localparam int LO_W = SUM_W / 2;
	localparam int HI_W = SUM_W - LO_W;
	localparam int PROD_W = SUM_W + MB_W;
	localparam int FRAC_DROP = 16;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 2 * COORD_W + DEPTH_W;

	localparam logic [COEF_W-1:0] KINV_ONE = 32'h0100_0000;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX_RST = 16'hFFFF;
	localparam logic [STEP_W-1:0] STEP_RST = 8'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KINV_XU = 3'd0,
		REG_KINV_XV = 3'd1,
		REG_KINV_XC = 3'd2,
		REG_KINV_YV = 3'd3,
		REG_KINV_YC = 3'd4,
		REG_DEPTH_MIN = 3'd5,
		REG_DEPTH_MAX = 3'd6,
		REG_SUB_STEP = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_XU,
		ST_XV,
		ST_XLO,
		ST_XHI,
		ST_YV,
		ST_YLO,
		ST_YHI,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		A_XU,
		A_XV,
		A_YV,
		A_LO,
		A_HI
	} a_sel_t;

	typedef enum logic [1:0] {
		B_COL,
		B_ROW,
		B_DEPTH
	} b_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD_X,
		ACC_LOAD_Y,
		ACC_MUL,
		ACC_MAC,
		ACC_MAC_HI
	} acc_op_t;

	typedef struct packed {
		a_sel_t a_sel;
		b_sel_t b_sel;
		acc_op_t acc_op;
		logic sum_save;
		logic x_save;
		logic capture;
		logic emit;
	} dp_cmd_t;

endpackage

[src/dpb_ctrl.sv]
// Sequencer for one pixel: steps the shared multiply-accumulate through X then Y.
// Depends on dpb_pkg.
module dpb_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic out_busy,
	output dpb_pkg::dp_cmd_t cmd
);
	import dpb_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		cmd = '{a_sel: A_XU, b_sel: B_COL, acc_op: ACC_HOLD, sum_save: 1'b0,
			x_save: 1'b0, capture: 1'b0, emit: 1'b0};
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_XU;
				end
			end
			ST_XU: begin
				cmd.a_sel = A_XU;
				cmd.b_sel = B_COL;
				cmd.acc_op = ACC_LOAD_X;
				state_d = ST_XV;
			end
			ST_XV: begin
				cmd.a_sel = A_XV;
				cmd.b_sel = B_ROW;
				cmd.acc_op = ACC_MAC;
				cmd.sum_save = 1'b1;
				state_d = ST_XLO;
			end
			ST_XLO: begin
				cmd.a_sel = A_LO;
				cmd.b_sel = B_DEPTH;
				cmd.acc_op = ACC_MUL;
				state_d = ST_XHI;
			end
			ST_XHI: begin
				cmd.a_sel = A_HI;
				cmd.b_sel = B_DEPTH;
				cmd.acc_op = ACC_MAC_HI;
				state_d = ST_YV;
			end
			ST_YV: begin
				// X product is final in acc; latch it while Y starts
				cmd.x_save = 1'b1;
				cmd.a_sel = A_YV;
				cmd.b_sel = B_ROW;
				cmd.acc_op = ACC_LOAD_Y;
				cmd.sum_save = 1'b1;
				state_d = ST_YLO;
			end
			ST_YLO: begin
				cmd.a_sel = A_LO;
				cmd.b_sel = B_DEPTH;
				cmd.acc_op = ACC_MUL;
				state_d = ST_YHI;
			end
			ST_YHI: begin
				cmd.a_sel = A_HI;
				cmd.b_sel = B_DEPTH;
				cmd.acc_op = ACC_MAC_HI;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_busy) begin
					cmd.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[src/dpb_datapath.sv]
// Datapath: config registers, pixel counters, shared 32x17 multiply-accumulate,
// rounding/saturation and the output register. Depends on dpb_pkg.
module dpb_datapath (
	input logic clk,
	input logic arst_n,
	input dpb_pkg::dp_cmd_t cmd,
	output logic out_busy,
	input logic cfg_we,
	input logic [dpb_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [dpb_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic [dpb_pkg::DEPTH_W-1:0] in_depth,
	input logic in_row_end,
	input logic in_frame_end,
	output logic out_valid,
	input logic out_ready,
	output logic signed [dpb_pkg::COORD_W-1:0] point_x,
	output logic signed [dpb_pkg::COORD_W-1:0] point_y,
	output logic [dpb_pkg::DEPTH_W-1:0] point_z,
	output logic point_kept,
	output logic last_of_frame
);
	import dpb_pkg::*;

	localparam int Q_W = PROD_W - FRAC_DROP;
	localparam logic signed [PROD_W-1:0] RND_BIAS =
		{{(PROD_W-FRAC_DROP){1'b0}}, 1'b1, {(FRAC_DROP-1){1'b0}}};
	localparam logic signed [Q_W-1:0] Q_HI =
		{{(Q_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] Q_LO = ~Q_HI;
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

	// Q.24 product -> Q.8, round half up, clamp to COORD_W bits
	function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] r;
		logic signed [Q_W-1:0] q;
		r = p + RND_BIAS;
		q = signed'(r[PROD_W-1:FRAC_DROP]);
		if (q > Q_HI) begin
			q = Q_HI;
		end else if (q < Q_LO) begin
			q = Q_LO;
		end
		return q[COORD_W-1:0];
	endfunction

	logic signed [COEF_W-1:0] kxu_q, kxv_q, kxc_q, kyv_q, kyc_q;
	logic [DEPTH_W-1:0] dmin_q, dmax_q;
	logic [STEP_W-1:0] step_q;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [STEP_W-1:0] phase_q;

	logic [DEPTH_W-1:0] depth_q;
	logic row_end_q, frame_end_q, kept_q;

	logic signed [PROD_W-1:0] acc_q, acc_d;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [COORD_W-1:0] x_q;

	logic signed [COEF_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [MUL_W-1:0] mul;
	logic signed [PROD_W-1:0] mul_ext, xc_ext, yc_ext;

	logic [STEP_W-1:0] step_eff;
	logic [STEP_W:0] phase_inc;
	logic in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kxu_q <= KINV_ONE;
			kxv_q <= '0;
			kxc_q <= '0;
			kyv_q <= KINV_ONE;
			kyc_q <= '0;
			dmin_q <= '0;
			dmax_q <= DEPTH_MAX_RST;
			step_q <= STEP_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KINV_XU: kxu_q <= cfg_data;
				REG_KINV_XV: kxv_q <= cfg_data;
				REG_KINV_XC: kxc_q <= cfg_data;
				REG_KINV_YV: kyv_q <= cfg_data;
				REG_KINV_YC: kyc_q <= cfg_data;
				REG_DEPTH_MIN: dmin_q <= cfg_data[DEPTH_W-1:0];
				REG_DEPTH_MAX: dmax_q <= cfg_data[DEPTH_W-1:0];
				REG_SUB_STEP: step_q <= cfg_data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_range = (in_depth >= dmin_q) && (in_depth < dmax_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			depth_q <= in_depth;
			row_end_q <= in_row_end;
			frame_end_q <= in_frame_end;
			kept_q <= in_range && (phase_q == '0);
		end
	end

	// pixel position; advances once the result is handed to the output register
	assign step_eff = (step_q == '0) ? STEP_W'(1) : step_q;
	assign phase_inc = {1'b0, phase_q} + (STEP_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			phase_q <= '0;
		end else if (cmd.emit) begin
			if (frame_end_q) begin
				col_q <= '0;
				row_q <= '0;
				phase_q <= '0;
			end else begin
				phase_q <= (phase_inc >= {1'b0, step_eff}) ? '0 : phase_inc[STEP_W-1:0];
				if (row_end_q) begin
					col_q <= '0;
					if (row_q < ROW_LAST) begin
						row_q <= row_q + ROW_W'(1);
					end
				end else if (col_q < COL_LAST) begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	always_comb begin
		case (cmd.a_sel)
			A_XU: mul_a = kxu_q;
			A_XV: mul_a = kxv_q;
			A_YV: mul_a = kyv_q;
			A_LO: mul_a = signed'({{(COEF_W-LO_W){1'b0}}, sum_q[LO_W-1:0]});
			A_HI: mul_a = {{(COEF_W-HI_W){sum_q[SUM_W-1]}}, sum_q[SUM_W-1:LO_W]};
			default: mul_a = kxu_q;
		endcase
		case (cmd.b_sel)
			B_COL: mul_b = signed'({{(MB_W-COL_W){1'b0}}, col_q});
			B_ROW: mul_b = signed'({{(MB_W-ROW_W){1'b0}}, row_q});
			B_DEPTH: mul_b = signed'({1'b0, depth_q});
			default: mul_b = signed'({1'b0, depth_q});
		endcase
	end

	assign mul = mul_a * mul_b;
	assign mul_ext = {{(PROD_W-MUL_W){mul[MUL_W-1]}}, mul};
	assign xc_ext = {{(PROD_W-COEF_W){kxc_q[COEF_W-1]}}, kxc_q};
	assign yc_ext = {{(PROD_W-COEF_W){kyc_q[COEF_W-1]}}, kyc_q};

	always_comb begin
		case (cmd.acc_op)
			ACC_HOLD: acc_d = acc_q;
			ACC_LOAD_X: acc_d = mul_ext + xc_ext;
			ACC_LOAD_Y: acc_d = mul_ext + yc_ext;
			ACC_MUL: acc_d = mul_ext;
			ACC_MAC: acc_d = acc_q + mul_ext;
			ACC_MAC_HI: acc_d = acc_q + (mul_ext <<< LO_W);
			default: acc_d = acc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_d;
		if (cmd.sum_save) begin
			sum_q <= acc_d[SUM_W-1:0];
		end
		if (cmd.x_save) begin
			x_q <= round_sat(acc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			point_x <= x_q;
			point_y <= round_sat(acc_q);
			point_z <= depth_q;
			point_kept <= kept_q;
			last_of_frame <= frame_end_q;
		end
	end

	assign out_busy = out_valid && !out_ready;

endmodule

[src/depth_pixel_backprojection.sv]
// Top level of the depth pixel back-projection block: stream ports, config port,
// controller and datapath. Depends on dpb_pkg, dpb_ctrl and dpb_datapath.
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    tdata: depth_mm; tuser: row_end; tlast: frame_end
// m_*      out  m_tvalid/m_tready    tdata: point_x, point_y, point_z; tuser: point_kept;
//                                    tlast: last_of_frame
// cfg_*    in   cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//
// One pixel is handled as accept, then 8 steps through the single 32x17 signed
// multiply-accumulate (3 for the coefficient sums, 2 partial products per coordinate,
// plus output load). The output register holds a finished point while the next pixel
// is taken; a stalled m_tready blocks only the output-load step.
// arst_n clears the controller, counters and output valid and sets the config registers to their defaults.
module depth_pixel_backprojection (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [dpb_pkg::S_TDATA_W-1:0] s_tdata, // [15:0] depth_mm
	input logic s_tuser, // [0] row_end
	input logic s_tlast, // frame_end
	output logic m_tvalid,
	input logic m_tready,
	output logic [dpb_pkg::M_TDATA_W-1:0] m_tdata, // [39:0] point_x, [79:40] point_y, [95:80] point_z
	output logic m_tuser, // [0] point_kept
	output logic m_tlast, // last_of_frame
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [dpb_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [dpb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dpb_pkg::*;

	dp_cmd_t cmd;
	logic out_busy;
	logic signed [COORD_W-1:0] point_x, point_y;
	logic [DEPTH_W-1:0] point_z;

	assign cfg_ready = 1'b1;

	dpb_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.out_busy(out_busy),
		.cmd(cmd)
	);

	dpb_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.out_busy(out_busy),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_depth(s_tdata[DEPTH_W-1:0]),
		.in_row_end(s_tuser),
		.in_frame_end(s_tlast),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.point_kept(m_tuser),
		.last_of_frame(m_tlast)
	);

	assign m_tdata = {point_z, point_y, point_x};

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while a pixel is in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(m_tvalid && !m_tready))
		else $error("output register loaded while holding an untaken point");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid)
		else $error("emitted point not presented");

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> s_tready)
		else $error("controller not back in idle after emit");
`endif

endmodule
